>>> rtl/fpbp_pkg.sv
package fpbp_pkg;

    // Directory geometry.
    localparam int FRAMES       = 16;
    localparam int PAGE_ID_BITS = 16;

    // Field widths fixed by the interface.
    localparam int CAP_W       = 5;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int FRAME_OUT_W = 4;

    // Derived widths.
    localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int PCOUNT_W = PAGE_ID_BITS + 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_GET    = 3'd0,
        FUNC_MARK   = 3'd1,
        FUNC_FLUSH  = 3'd2,
        FUNC_CLEAR  = 3'd3,
        FUNC_CREATE = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT    = 3'd0,
        ST_LOADED = 3'd1,
        ST_RANGE  = 3'd2,
        ST_ABSENT = 3'd3,
        ST_DONE   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted item
        logic evict;   // retire the oldest frame
        logic finish;  // apply the item and write one result
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;   // the result register can take a result this cycle
        logic evict_req;  // the held item is a get miss on a full pool
        logic more;       // a flush still has dirty frames after this result
    } dp_stat_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } pick_t;

    // Lowest set bit of a per-frame vector.
    function automatic pick_t first_set(input logic [FRAMES-1:0] vec);
        pick_t r;
        r = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (vec[i]) begin
                r.found = 1'b1;
                r.idx   = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/fpbp_ctrl.sv
module fpbp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fpbp_pkg::dp_stat_t  stat,
    output fpbp_pkg::ctrl_cmd_t cmd
);
    import fpbp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free && !stat.more) begin
                    state_next = s_valid ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.evict  = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_EXEC: begin
                cmd.evict = stat.evict_req;
            end
            S_FINISH: begin
                cmd.finish = stat.out_free;
                s_ready    = stat.out_free && !stat.more;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.load = s_valid && s_ready;
    end

endmodule

>>> rtl/fpbp_dp.sv
module fpbp_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fpbp_pkg::ctrl_cmd_t                 cmd,
    output fpbp_pkg::dp_stat_t                  stat,
    input  logic                                cfg_valid,
    input  logic [fpbp_pkg::CAP_W-1:0]          cfg_data,
    input  logic [fpbp_pkg::FUNC_W-1:0]         s_func,
    input  logic [fpbp_pkg::PAGE_ID_BITS-1:0]   s_page_id,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fpbp_pkg::STATUS_W-1:0]       m_status,
    output logic [fpbp_pkg::FRAME_OUT_W-1:0]    m_frame_index,
    output logic                                m_fetch_valid,
    output logic [fpbp_pkg::PAGE_ID_BITS-1:0]   m_fetch_page,
    output logic                                m_writeback_valid,
    output logic [fpbp_pkg::PAGE_ID_BITS-1:0]   m_writeback_page,
    output logic [fpbp_pkg::PAGE_ID_BITS-1:0]   m_created_page,
    output logic                                m_last
);
    import fpbp_pkg::*;

    // Held item and configuration.
    logic [FUNC_W-1:0]       func_reg;
    logic [PAGE_ID_BITS-1:0] pid_reg;
    logic [CAP_W-1:0]        capacity_reg;

    // Directory state.
    logic [PAGE_ID_BITS-1:0] frame_page_reg [FRAMES];
    logic [FRAMES-1:0]       frame_valid_reg;
    logic [FRAMES-1:0]       frame_dirty_reg;
    logic [IDX_W-1:0]        fifo_order_reg [FRAMES];
    logic [IDX_W-1:0]        fifo_head_reg;
    logic [CNT_W-1:0]        resident_count_reg;
    logic [PCOUNT_W-1:0]     page_count_reg;

    // Write-back produced by the eviction step of a get.
    logic                    wb_valid_reg;
    logic [PAGE_ID_BITS-1:0] wb_page_reg;

    // Result register.
    logic                    m_valid_reg;
    logic [STATUS_W-1:0]     m_status_reg;
    logic [FRAME_OUT_W-1:0]  m_frame_index_reg;
    logic                    m_fetch_valid_reg;
    logic [PAGE_ID_BITS-1:0] m_fetch_page_reg;
    logic                    m_writeback_valid_reg;
    logic [PAGE_ID_BITS-1:0] m_writeback_page_reg;
    logic [PAGE_ID_BITS-1:0] m_created_page_reg;
    logic                    m_last_reg;

    logic [FRAMES-1:0]       match;
    logic [FRAMES-1:0]       dirty_vec;
    logic [FRAMES-1:0]       dirty_rest;
    pick_t                   hit;
    pick_t                   free_pick;
    pick_t                   flush_pick;
    logic [CMP_W-1:0]        cap_eff;
    logic [CMP_W-1:0]        count_wide;
    logic                    pool_full;
    logic [IDX_W-1:0]        victim;
    logic [IDX_W-1:0]        rd_idx;
    logic [PAGE_ID_BITS-1:0] rd_page;
    logic [SUM_W-1:0]        tail_sum;
    logic [IDX_W-1:0]        tail;
    logic [IDX_W-1:0]        head_inc;
    logic                    pid_past_end;
    logic                    ids_exhausted;
    logic                    do_load;

    logic [STATUS_W-1:0]     res_status;
    logic [FRAME_OUT_W-1:0]  res_frame;
    logic                    res_fetch_valid;
    logic [PAGE_ID_BITS-1:0] res_fetch_page;
    logic                    res_wb_valid;
    logic [PAGE_ID_BITS-1:0] res_wb_page;
    logic [PAGE_ID_BITS-1:0] res_created;
    logic                    res_last;

    // Tag compare against every frame at once.
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            match[i] = frame_valid_reg[i] && (frame_page_reg[i] == pid_reg);
        end
    end

    assign hit        = first_set(match);
    assign free_pick  = first_set(~frame_valid_reg);
    assign dirty_vec  = frame_valid_reg & frame_dirty_reg;
    assign flush_pick = first_set(dirty_vec);
    assign dirty_rest = dirty_vec & ~(FRAMES'(1) << flush_pick.idx);

    // Capacity zero acts as one, values above the frame count saturate.
    always_comb begin
        cap_eff = CMP_W'(capacity_reg);
        if (cap_eff == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_eff > CMP_W'(FRAMES)) begin
            cap_eff = CMP_W'(FRAMES);
        end
    end

    assign count_wide = CMP_W'(resident_count_reg);
    assign pool_full  = (resident_count_reg != '0) && (count_wide >= cap_eff);

    assign victim  = fifo_order_reg[fifo_head_reg];
    assign rd_idx  = cmd.evict ? victim : flush_pick.idx;
    assign rd_page = frame_page_reg[rd_idx];

    // Queue tail is head plus residency, wrapped once.
    always_comb begin
        tail_sum = SUM_W'(fifo_head_reg) + SUM_W'(resident_count_reg);
        if (tail_sum >= SUM_W'(FRAMES)) begin
            tail_sum = tail_sum - SUM_W'(FRAMES);
        end
        tail = tail_sum[IDX_W-1:0];
    end

    assign head_inc = (fifo_head_reg == IDX_W'(FRAMES - 1)) ? '0 : fifo_head_reg + IDX_W'(1);

    assign pid_past_end  = {1'b0, pid_reg} >= page_count_reg;
    assign ids_exhausted = page_count_reg[PCOUNT_W-1];
    assign do_load       = !hit.found && !pid_past_end && free_pick.found;

    assign stat.out_free  = !m_valid_reg || m_ready;
    assign stat.evict_req = (func_reg == FUNC_GET) && !hit.found && pool_full;
    assign stat.more      = (func_reg == FUNC_FLUSH) && flush_pick.found && (|dirty_rest);

    // Result of the held item.
    always_comb begin
        res_status      = ST_DONE;
        res_frame       = '0;
        res_fetch_valid = 1'b0;
        res_fetch_page  = '0;
        res_wb_valid    = 1'b0;
        res_wb_page     = '0;
        res_created     = '0;
        res_last        = 1'b1;
        case (func_reg)
            FUNC_GET: begin
                if (hit.found) begin
                    res_status = ST_HIT;
                    res_frame  = FRAME_OUT_W'(hit.idx);
                end else begin
                    res_wb_valid = wb_valid_reg;
                    res_wb_page  = wb_valid_reg ? wb_page_reg : '0;
                    if (do_load) begin
                        res_status      = ST_LOADED;
                        res_frame       = FRAME_OUT_W'(free_pick.idx);
                        res_fetch_valid = 1'b1;
                        res_fetch_page  = pid_reg;
                    end else begin
                        res_status = ST_RANGE;
                    end
                end
            end
            FUNC_MARK: begin
                if (hit.found) begin
                    res_frame = FRAME_OUT_W'(hit.idx);
                end else begin
                    res_status = ST_ABSENT;
                end
            end
            FUNC_FLUSH: begin
                if (flush_pick.found) begin
                    res_frame    = FRAME_OUT_W'(flush_pick.idx);
                    res_wb_valid = 1'b1;
                    res_wb_page  = rd_page;
                    res_last     = !(|dirty_rest);
                end
            end
            FUNC_CREATE: begin
                if (ids_exhausted) begin
                    res_status = ST_RANGE;
                end else begin
                    res_created = page_count_reg[PAGE_ID_BITS-1:0];
                end
            end
            default: begin
                res_status = ST_DONE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg       <= CAP_W'(FRAMES);
            frame_valid_reg    <= '0;
            frame_dirty_reg    <= '0;
            fifo_head_reg      <= '0;
            resident_count_reg <= '0;
            page_count_reg     <= '0;
            wb_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                capacity_reg <= cfg_data;
            end
            if (cmd.load) begin
                wb_valid_reg <= 1'b0;
            end
            if (cmd.evict) begin
                fifo_head_reg           <= head_inc;
                resident_count_reg      <= resident_count_reg - CNT_W'(1);
                wb_valid_reg            <= frame_dirty_reg[victim];
                frame_valid_reg[victim] <= 1'b0;
                frame_dirty_reg[victim] <= 1'b0;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
                case (func_reg)
                    FUNC_GET: begin
                        if (do_load) begin
                            frame_valid_reg[free_pick.idx] <= 1'b1;
                            frame_dirty_reg[free_pick.idx] <= 1'b0;
                            resident_count_reg <= resident_count_reg + CNT_W'(1);
                        end
                    end
                    FUNC_MARK: begin
                        if (hit.found) begin
                            frame_dirty_reg[hit.idx] <= 1'b1;
                        end
                    end
                    FUNC_FLUSH: begin
                        if (flush_pick.found) begin
                            frame_dirty_reg[flush_pick.idx] <= 1'b0;
                        end
                    end
                    FUNC_CLEAR: begin
                        frame_valid_reg    <= '0;
                        frame_dirty_reg    <= '0;
                        fifo_head_reg      <= '0;
                        resident_count_reg <= '0;
                    end
                    FUNC_CREATE: begin
                        if (!ids_exhausted) begin
                            page_count_reg <= page_count_reg + PCOUNT_W'(1);
                        end
                    end
                    default: begin
                        page_count_reg <= page_count_reg;
                    end
                endcase
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload state.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            pid_reg  <= s_page_id;
        end
        if (cmd.evict) begin
            wb_page_reg <= rd_page;
        end
        if (cmd.finish) begin
            if ((func_reg == FUNC_GET) && do_load) begin
                frame_page_reg[free_pick.idx] <= pid_reg;
                fifo_order_reg[tail]          <= free_pick.idx;
            end
            m_status_reg          <= res_status;
            m_frame_index_reg     <= res_frame;
            m_fetch_valid_reg     <= res_fetch_valid;
            m_fetch_page_reg      <= res_fetch_page;
            m_writeback_valid_reg <= res_wb_valid;
            m_writeback_page_reg  <= res_wb_page;
            m_created_page_reg    <= res_created;
            m_last_reg            <= res_last;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_frame_index     = m_frame_index_reg;
    assign m_fetch_valid     = m_fetch_valid_reg;
    assign m_fetch_page      = m_fetch_page_reg;
    assign m_writeback_valid = m_writeback_valid_reg;
    assign m_writeback_page  = m_writeback_page_reg;
    assign m_created_page    = m_created_page_reg;
    assign m_last            = m_last_reg;

endmodule

>>> rtl/fifo_page_buffer_pool.sv
// Page-frame directory with first-in first-out replacement and dirty tracking.
// Each input transfer carries an operation and a page id and produces one
// result transfer, except flush, which produces one result per dirty frame in
// ascending frame order (one result if none is dirty), with last set on the
// final one. A get runs through an exec step, for the tag compare against all
// frames and, on a miss with a full pool, retirement of the oldest frame, then
// a finish step, which picks the lowest free frame and writes the result. Every
// other operation runs the same steps; a flush stays in the finish step while
// dirty frames remain, since it walks them through the single result register.
// The next item is taken in the same cycle that the current one writes its last
// result, so back-to-back traffic goes from one item's finish step straight to
// the exec step of the next. A result waits in the output register until it is
// taken, and the block holds the current item meanwhile. Capacity is written
// through the cfg channel, which is always ready; write it only while the
// block is idle. There is no clearing pass after reset: the pool starts empty.
module fifo_page_buffer_pool (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fpbp_pkg::CAP_W-1:0]          cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fpbp_pkg::FUNC_W-1:0]         s_func,
    input  logic [fpbp_pkg::PAGE_ID_BITS-1:0]   s_page_id,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fpbp_pkg::STATUS_W-1:0]       m_status,
    output logic [fpbp_pkg::FRAME_OUT_W-1:0]    m_frame_index,
    output logic                                m_fetch_valid,
    output logic [fpbp_pkg::PAGE_ID_BITS-1:0]   m_fetch_page,
    output logic                                m_writeback_valid,
    output logic [fpbp_pkg::PAGE_ID_BITS-1:0]   m_writeback_page,
    output logic [fpbp_pkg::PAGE_ID_BITS-1:0]   m_created_page,
    output logic                                m_last
);
    import fpbp_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // The capacity register can take a write in any cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences accept, eviction and the result step.
    fpbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the directory, the replacement queue and the result register.
    fpbp_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_valid         (cfg_valid),
        .cfg_data          (cfg_data),
        .s_func            (s_func),
        .s_page_id         (s_page_id),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_frame_index     (m_frame_index),
        .m_fetch_valid     (m_fetch_valid),
        .m_fetch_page      (m_fetch_page),
        .m_writeback_valid (m_writeback_valid),
        .m_writeback_page  (m_writeback_page),
        .m_created_page    (m_created_page),
        .m_last            (m_last)
    );

endmodule
